>>> sv/ote_pkg.sv
package ote_pkg;

    localparam int MAX_PARTS = 64;
    localparam int ADDR_W    = $clog2(MAX_PARTS);
    localparam int VAL_W     = 31;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_SET    = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_RANGE    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   part_index;
        logic [VAL_W-1:0]   amount;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0]   start_offset;
        logic [VAL_W-1:0]   part_size;
        logic [VAL_W-1:0]   max_other_size;
        logic [VAL_W-1:0]   total_size;
        logic [CNT_W-1:0]   part_count;
        t_status            status;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CALC,
        S_CHECK,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic do_clear;
        logic do_append;
        logic do_range;
        logic scan_start;
        logic scan_run;
        logic calc;
        logic set_fail;
        logic sweep_start;
        logic sweep_run;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  range_err;
        logic  scan_done;
        logic  set_ovf;
        logic  sweep_done;
        logic  out_free;
    } t_stat;

endpackage

>>> sv/ote_ctrl.sv
module ote_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ote_pkg::t_stat i_stat,
    output ote_pkg::t_cmd  o_cmd
);
    import ote_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.kind)
                    KIND_CLEAR, KIND_APPEND: n_state = S_DONE;
                    default: n_state = i_stat.range_err ? S_DONE : S_SCAN;
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = (i_stat.kind == KIND_SET) ? S_CALC : S_DONE;
                end
            end
            S_CALC: n_state = S_CHECK;
            S_CHECK: n_state = i_stat.set_ovf ? S_DONE : S_SWEEP;
            S_SWEEP: begin
                if (i_stat.sweep_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // nothing is taken while reset is held
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            S_DECODE: begin
                case (i_stat.kind)
                    KIND_CLEAR:  o_cmd.do_clear  = 1'b1;
                    KIND_APPEND: o_cmd.do_append = 1'b1;
                    default: begin
                        o_cmd.do_range   = i_stat.range_err;
                        o_cmd.scan_start = !i_stat.range_err;
                    end
                endcase
            end
            S_SCAN:  o_cmd.scan_run = 1'b1;
            S_CALC:  o_cmd.calc = 1'b1;
            S_CHECK: begin
                o_cmd.set_fail    = i_stat.set_ovf;
                o_cmd.sweep_start = !i_stat.set_ovf;
            end
            S_SWEEP: o_cmd.sweep_run = 1'b1;
            S_DONE:  o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> sv/ote_dp.sv
module ote_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ote_pkg::t_in_word  i_in_word,
    output ote_pkg::t_out_word o_out_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ote_pkg::t_cmd      i_cmd,
    output ote_pkg::t_stat     o_stat
);
    import ote_pkg::*;

    // entry k of the offset table (k >= 1) lives at address k-1; entry zero is always zero
    logic [VAL_W-1:0]  r_mem [MAX_PARTS];
    logic [VAL_W-1:0]  r_rd_data;

    t_kind             r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic [VAL_W-1:0]  r_amount;

    logic [CNT_W-1:0]  r_count;
    logic [VAL_W-1:0]  r_total;

    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_pk;
    logic [CNT_W-1:0]  r_hi;
    logic [CNT_W-1:0]  r_lo;
    logic              r_pend;
    logic [VAL_W-1:0]  r_prev;
    logic [VAL_W-1:0]  r_diff;
    logic [VAL_W-1:0]  r_delta;

    logic [VAL_W-1:0]  r_res_start;
    logic [VAL_W-1:0]  r_res_psize;
    logic [VAL_W-1:0]  r_res_max;
    t_status           r_res_status;

    t_out_word         r_out_word;
    logic              r_out_valid;

    logic [VAL_W:0]    app_sum;
    logic [VAL_W:0]    chk_sum;
    logic              full;
    logic              range_err;
    logic              scan_issue;
    logic              sweep_issue;
    logic [VAL_W-1:0]  data_k;
    logic [VAL_W-1:0]  seg;
    logic [CNT_W-1:0]  idx_ext;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_free;

    assign idx_ext     = {1'b0, r_idx};
    assign app_sum     = {1'b0, r_total} + {1'b0, r_amount};
    assign chk_sum     = {1'b0, r_diff} + {1'b0, r_amount};
    assign full        = (r_count == CNT_W'(MAX_PARTS));
    assign range_err   = (idx_ext >= r_count);
    assign scan_issue  = i_cmd.scan_run && (r_k <= r_hi);
    assign sweep_issue = i_cmd.sweep_run && (r_k <= r_count);
    assign data_k      = (r_pk == '0) ? '0 : r_rd_data;
    assign seg         = data_k - r_prev;
    assign rd_addr     = ADDR_W'(r_k - CNT_W'(1));
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = ADDR_W'(r_count);
        wr_data = app_sum[VAL_W-1:0];
        if (i_cmd.do_append && !full && !app_sum[VAL_W]) begin
            mem_we = 1'b1;
        end else if (i_cmd.sweep_run && r_pend) begin
            mem_we  = 1'b1;
            wr_addr = ADDR_W'(r_pk - CNT_W'(1));
            wr_data = r_rd_data + r_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_clear) begin
                r_count <= '0;
                r_total <= '0;
            end
            if (i_cmd.do_append && !full && !app_sum[VAL_W]) begin
                r_count <= r_count + CNT_W'(1);
                r_total <= app_sum[VAL_W-1:0];
            end
            if (i_cmd.sweep_start) begin
                r_total <= chk_sum[VAL_W-1:0];
            end
            if (i_cmd.scan_start || i_cmd.sweep_start) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_pend <= scan_issue;
            end else if (i_cmd.sweep_run) begin
                r_pend <= sweep_issue;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_in_word.kind;
            r_idx    <= i_in_word.part_index;
            r_amount <= i_in_word.amount;
        end
        if (i_cmd.do_clear || i_cmd.do_range || i_cmd.set_fail) begin
            r_res_start  <= '0;
            r_res_psize  <= '0;
            r_res_max    <= '0;
            r_res_status <= i_cmd.do_clear ? ST_OK :
                            (i_cmd.do_range ? ST_RANGE : ST_OVERFLOW);
        end
        if (i_cmd.do_append) begin
            r_res_max <= '0;
            if (full) begin
                r_res_start  <= '0;
                r_res_psize  <= '0;
                r_res_status <= ST_FULL;
            end else if (app_sum[VAL_W]) begin
                r_res_start  <= '0;
                r_res_psize  <= '0;
                r_res_status <= ST_OVERFLOW;
            end else begin
                r_res_start  <= r_total;
                r_res_psize  <= r_amount;
                r_res_status <= ST_OK;
            end
        end
        if (i_cmd.scan_start) begin
            // set size only needs entries idx and idx+1, a query walks the whole table
            if (r_kind == KIND_SET) begin
                r_k  <= idx_ext;
                r_lo <= idx_ext;
                r_hi <= idx_ext + CNT_W'(1);
            end else begin
                r_k  <= '0;
                r_lo <= '0;
                r_hi <= r_count;
            end
            r_prev       <= '0;
            r_res_start  <= '0;
            r_res_psize  <= '0;
            r_res_max    <= '0;
            r_res_status <= ST_OK;
        end
        if (scan_issue || sweep_issue) begin
            r_k  <= r_k + CNT_W'(1);
            r_pk <= r_k;
        end
        if (i_cmd.scan_run && r_pend) begin
            r_prev <= data_k;
            if (r_pk != r_lo) begin
                if ((r_pk - CNT_W'(1)) == idx_ext) begin
                    r_res_start <= r_prev;
                    r_res_psize <= seg;
                end else if (seg > r_res_max) begin
                    r_res_max <= seg;
                end
            end
        end
        if (i_cmd.calc) begin
            // r_res_psize holds the old size here
            r_diff  <= r_total - r_res_psize;
            r_delta <= r_amount - r_res_psize;
        end
        if (i_cmd.sweep_start) begin
            r_k         <= idx_ext + CNT_W'(1);
            r_res_psize <= r_amount;
        end
        if (i_cmd.out_load) begin
            r_out_word.start_offset   <= r_res_start;
            r_out_word.part_size      <= r_res_psize;
            r_out_word.max_other_size <= r_res_max;
            r_out_word.total_size     <= r_total;
            r_out_word.part_count     <= r_count;
            r_out_word.status         <= r_res_status;
        end
    end

    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.range_err  = range_err;
        o_stat.scan_done  = (r_k > r_hi) && !r_pend;
        o_stat.set_ovf    = chk_sum[VAL_W];
        o_stat.sweep_done = (r_k > r_count) && !r_pend;
        o_stat.out_free   = out_free;
    end

    assign o_out_word  = r_out_word;
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/offset_table_engine.sv
// flow from accept to result valid: clear, append and an index out of range go from decode
// straight to the result; a query walks the whole table; set size makes two reads,
// a check, then a read-modify-write walk over the later offsets, and stops after the check if it would overflow
// throughput: one word at a time, the next accepted in the cycle after the result loads;
// a stalled result holds the next word off
// reset: synchronous active low, empties the table at once; no clearing pass
module offset_table_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ote_pkg::t_in_word  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ote_pkg::t_out_word o_out_word
);
    import ote_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ote_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ote_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    // one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.part_count <= CNT_W'(MAX_PARTS)))
        else $error("part count above table size");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != ST_OK)) |->
        (o_out_word.start_offset == '0 && o_out_word.part_size == '0
         && o_out_word.max_other_size == '0))
        else $error("refused word carries nonzero fields");

    a_part_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_OK)) |->
        (({1'b0, o_out_word.start_offset} + {1'b0, o_out_word.part_size})
         <= {1'b0, o_out_word.total_size}))
        else $error("part extends past total");

endmodule
